[hw/rtl/tabu_pkg.sv]
// Package for the tiered arena bump allocator: sizing constants, tier tables,
// sequencer state type and the control struct for the space register file.
// No dependencies.
`timescale 1ns / 1ps

package tabu_pkg;

    // Pool geometry
    localparam int NUM_TIERS   = 8;
    localparam int BASE_SIZE   = 128;
    localparam int ALIGN_BYTES = 8;     // power of two: round-up is an add and a mask

    // Fixed word field widths
    localparam int SIZE_W = 16;
    localparam int ADDR_W = 15;
    localparam int TOUT_W = 3;

    // Derived widths
    localparam int IDX_W  = (NUM_TIERS > 1) ? $clog2(NUM_TIERS) : 1;
    localparam int CAP_W  = $clog2((BASE_SIZE << (NUM_TIERS - 1)) + 1);
    localparam int END_W  = $clog2(BASE_SIZE * ((2 ** NUM_TIERS) - 1) + 1);
    localparam int RND_W  = $clog2((2 ** SIZE_W) + ALIGN_BYTES - 1);
    localparam int SUB_W0 = (END_W > RND_W) ? END_W : RND_W;
    localparam int SUB_W  = (SUB_W0 > CAP_W) ? SUB_W0 : CAP_W;

    localparam logic [RND_W-1:0] ALIGN_M1 = RND_W'(ALIGN_BYTES - 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIERS - 1);

    // Full capacity of tier i
    function automatic logic [CAP_W-1:0] tier_cap(input logic [IDX_W-1:0] idx);
        logic [CAP_W-1:0] one_base;
        one_base = CAP_W'(BASE_SIZE);
        return one_base << idx;
    endfunction

    // Pool address one past the end of tier i: offset + capacity
    function automatic logic [SUB_W-1:0] tier_end(input logic [IDX_W-1:0] idx);
        logic [SUB_W-1:0] span;
        span = (SUB_W'(1) << (SUB_W'(idx) + SUB_W'(1))) - SUB_W'(1);
        return span * SUB_W'(BASE_SIZE);
    endfunction

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_ADDR = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    // Space register file control
    typedef struct packed {
        logic             refill;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
    } t_space_ctl;

endpackage

[hw/rtl/tabu_sub_unit.sv]
// Shared subtract/compare unit of the tiered arena bump allocator.
// Depends on tabu_pkg.
`timescale 1ns / 1ps

module tabu_sub_unit (
    input  logic [tabu_pkg::SUB_W-1:0] i_a,
    input  logic [tabu_pkg::SUB_W-1:0] i_b,
    output logic [tabu_pkg::SUB_W-1:0] o_diff,
    output logic                       o_borrow
);
    import tabu_pkg::*;

    logic [SUB_W:0] w_full;

    // borrow set when b > a
    assign w_full   = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = w_full[SUB_W-1:0];
    assign o_borrow = w_full[SUB_W];

endmodule

[hw/rtl/tabu_space_file.sv]
// Per-tier remaining space registers with one write port and a refill-all.
// Depends on tabu_pkg.
`timescale 1ns / 1ps

module tabu_space_file (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tabu_pkg::t_space_ctl       i_ctl,
    input  logic [tabu_pkg::CAP_W-1:0] i_wr_data,
    input  logic [tabu_pkg::IDX_W-1:0] i_rd_idx,
    output logic [tabu_pkg::CAP_W-1:0] o_rd_data
);
    import tabu_pkg::*;

    logic [CAP_W-1:0] r_space [NUM_TIERS];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_TIERS; i++) begin
            if (!i_rst_n || i_ctl.refill) begin
                r_space[i] <= tier_cap(IDX_W'(i));
            end else if (i_ctl.wr_en && (i_ctl.wr_idx == IDX_W'(i))) begin
                r_space[i] <= i_wr_data;
            end
        end
    end

    assign o_rd_data = r_space[i_rd_idx];

endmodule

[hw/rtl/tiered_arena_bump_allocator_unit.sv]
// Top level of the tiered arena bump allocator: sequencer, output register
// and configuration register. Depends on tabu_pkg, tabu_space_file and
// tabu_sub_unit.
`timescale 1ns / 1ps

// Usage
//   Input channel (i_in_valid / o_in_stall) carries one word: i_cmd and
//   i_alloc_size. i_cmd=0 allocates i_alloc_size bytes rounded up to the
//   alignment; i_cmd=1 refills every tier unless hold_on_reset is set.
//   Output channel (o_out_valid / i_out_stall) returns one word per input
//   word: o_address, o_tier, o_too_large.
//   i_cfg_wr_en / i_cfg_wr_data write hold_on_reset; write it only when idle.
// Timing
//   One shared subtractor does all arithmetic. The scan tests one tier per
//   cycle from tier 0 up; an allocate served by a tier then takes the address
//   step and loads the output register from the done state. A miss goes from
//   the last tier to the done state, a refill command straight there.
//   One word is in work at a time; o_in_stall is high while it is.
// Reset
//   Synchronous, active low: all tiers full, hold_on_reset cleared, no word pending.
// Back-pressure
//   While i_out_stall holds the output word, the next input word is still
//   taken and worked; its result waits in the done state until the output
//   register frees up.

module tiered_arena_bump_allocator_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic                         i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_cmd,
    input  logic [tabu_pkg::SIZE_W-1:0]  i_alloc_size,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [tabu_pkg::ADDR_W-1:0]  o_address,
    output logic [tabu_pkg::TOUT_W-1:0]  o_tier,
    output logic                         o_too_large
);
    import tabu_pkg::*;

    // Control
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_hold;
    logic               r_out_valid, n_out_valid;

    // Work registers
    logic [RND_W-1:0]   r_rnd, n_rnd;
    logic [CAP_W-1:0]   r_before, n_before;
    logic [ADDR_W-1:0]  r_res_addr, n_res_addr;
    logic               r_res_big, n_res_big;

    // Output word
    logic [ADDR_W-1:0]  r_address, n_address;
    logic [TOUT_W-1:0]  r_tier, n_tier;
    logic               r_too_large, n_too_large;

    // Datapath
    t_space_ctl         w_ctl;
    logic [CAP_W-1:0]   w_space;
    logic [SUB_W-1:0]   w_a, w_b, w_diff;
    logic               w_borrow;
    logic               w_in_acc;
    logic               w_out_free;
    logic [RND_W-1:0]   w_rnd;

    assign w_in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_rnd      = ({1'b0, i_alloc_size} + ALIGN_M1) & ~ALIGN_M1;

    tabu_space_file u_space (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_wr_data (w_diff[CAP_W-1:0]),
        .i_rd_idx  (r_idx),
        .o_rd_data (w_space)
    );

    tabu_sub_unit u_sub (
        .i_a      (w_a),
        .i_b      (w_b),
        .o_diff   (w_diff),
        .o_borrow (w_borrow)
    );

    // Operand select: scan tests space - rounded, address step forms
    // tier end - space before the grant.
    always_comb begin
        case (r_state)
            ST_ADDR: begin
                w_a = tier_end(r_idx);
                w_b = SUB_W'(r_before);
            end
            default: begin
                w_a = SUB_W'(w_space);
                w_b = SUB_W'(r_rnd);
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_rnd       = r_rnd;
        n_before    = r_before;
        n_res_addr  = r_res_addr;
        n_res_big   = r_res_big;
        n_out_valid = r_out_valid && i_out_stall;
        n_address   = r_address;
        n_tier      = r_tier;
        n_too_large = r_too_large;
        w_ctl       = '{refill: 1'b0, wr_en: 1'b0, wr_idx: r_idx};

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_idx      = '0;
                    n_rnd      = w_rnd;
                    n_res_addr = '0;
                    n_res_big  = 1'b0;
                    if (i_cmd) begin
                        w_ctl.refill = !r_hold;
                        n_state      = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (!w_borrow) begin
                    // tier fits: take the space now, address next cycle
                    w_ctl.wr_en = 1'b1;
                    n_before    = w_space;
                    n_state     = ST_ADDR;
                end else if (r_idx == LAST_IDX) begin
                    n_idx     = '0;
                    n_res_big = 1'b1;
                    n_state   = ST_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_ADDR: begin
                n_res_addr = w_diff[ADDR_W-1:0];
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_address   = r_res_addr;
                    n_tier      = TOUT_W'(r_idx);
                    n_too_large = r_res_big;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_hold      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_hold <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rnd       <= n_rnd;
        r_before    <= n_before;
        r_res_addr  <= n_res_addr;
        r_res_big   <= n_res_big;
        r_address   <= n_address;
        r_tier      <= n_tier;
        r_too_large <= n_too_large;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_address   = r_address;
    assign o_tier      = r_tier;
    assign o_too_large = r_too_large;

    // A failed allocate reports tier 0 at address 0
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_too_large) |-> (o_address == '0 && o_tier == '0))
        else $error("too_large word carries nonzero address or tier");

    // Scan index stays inside the tier set
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx <= LAST_IDX))
        else $error("tier index past last tier");

    // A refill command goes straight to the done state
    a_cmd_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_cmd) |=> (r_state == ST_DONE))
        else $error("refill command did not finish in one cycle");

    // The output word is only loaded from the done state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("output word loaded outside done state");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the tiered arena bump allocator: random-paced
// request words, an in-bench tier space tracker and in-order result checking.
// Depends on tabu_pkg and tiered_arena_bump_allocator_unit.
`timescale 1ns / 1ps

module tb_top;

    // Command codes carried in i_cmd
    localparam logic CMD_ALLOC  = 1'b0;
    localparam logic CMD_REFILL = 1'b1;

    // Receiver hold-off used to back the block up into its input
    localparam int SQUEEZE_CYCLES = 200;
    // Cycles to let pass once nothing is owed
    localparam int SETTLE_CYCLES  = 12;

    typedef struct packed {
        logic [tabu_pkg::ADDR_W-1:0] address;
        logic [tabu_pkg::TOUT_W-1:0] tier;
        logic                        too_large;
    } t_grant;

    // Tracks free bytes per tier and the grants the block still owes.
    class t_tier_tracker;
        int unsigned free_bytes[tabu_pkg::NUM_TIERS];
        bit          hold_refill;
        t_grant      grants_due[$];
        int          errors;

        function new();
            refill_tiers();
            hold_refill = 1'b0;
            errors      = 0;
        endfunction

        function void refill_tiers();
            for (int i = 0; i < tabu_pkg::NUM_TIERS; i++)
                free_bytes[i] = tabu_pkg::BASE_SIZE << i;
        endfunction

        function void set_hold(bit value);
            hold_refill = value;
        endfunction

        // Work out the grant for one accepted request word.
        function void take_request(logic cmd, logic [tabu_pkg::SIZE_W-1:0] size);
            t_grant      g;
            int unsigned need;
            int unsigned base_addr;
            g = '0;
            if (cmd == CMD_REFILL) begin
                if (!hold_refill)
                    refill_tiers();
                grants_due.push_back(g);
                return;
            end
            // kept 32 bits wide: 65535 rounds past 16 bits
            need = ((int'(size) + tabu_pkg::ALIGN_BYTES - 1) / tabu_pkg::ALIGN_BYTES)
                   * tabu_pkg::ALIGN_BYTES;
            g.too_large = 1'b1;
            for (int i = 0; i < tabu_pkg::NUM_TIERS; i++) begin
                if (free_bytes[i] >= need) begin
                    base_addr   = tabu_pkg::BASE_SIZE * ((1 << i) - 1);
                    g.address   = tabu_pkg::ADDR_W'(base_addr + (tabu_pkg::BASE_SIZE << i)
                                  - free_bytes[i]);
                    g.tier      = tabu_pkg::TOUT_W'(i);
                    g.too_large = 1'b0;
                    free_bytes[i] -= need;
                    break;
                end
            end
            grants_due.push_back(g);
        endfunction

        function void match_grant(logic [tabu_pkg::ADDR_W-1:0] address,
                                  logic [tabu_pkg::TOUT_W-1:0] tier, logic too_large);
            t_grant g;
            if (grants_due.size() == 0) begin
                $display("%0t: unexpected result word addr=%0d tier=%0d too_large=%0b",
                         $time, address, tier, too_large);
                errors++;
                return;
            end
            g = grants_due.pop_front();
            if (address !== g.address) begin
                $display("%0t: address expected %0d got %0d", $time, g.address, address);
                errors++;
            end
            if (tier !== g.tier) begin
                $display("%0t: tier expected %0d got %0d", $time, g.tier, tier);
                errors++;
            end
            if (too_large !== g.too_large) begin
                $display("%0t: too_large expected %0b got %0b", $time, g.too_large,
                         too_large);
                errors++;
            end
        endfunction

        function int owed();
            return grants_due.size();
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_wr_en;
    logic                        i_cfg_wr_data;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic                        i_cmd;
    logic [tabu_pkg::SIZE_W-1:0] i_alloc_size;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic [tabu_pkg::ADDR_W-1:0] o_address;
    logic [tabu_pkg::TOUT_W-1:0] o_tier;
    logic                        o_too_large;

    t_tier_tracker board = new();

    // Pacing controls shared by the sender and the receiver
    bit no_gaps     = 1'b0;   // both sides run flat out
    bit squeeze_req = 1'b0;   // receiver does one long hold-off

    tiered_arena_bump_allocator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_alloc_size  (i_alloc_size),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_address     (o_address),
        .o_tier        (o_tier),
        .o_too_large   (o_too_large)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous cap: a slow correct run needs well under a millisecond.
    initial begin
        #10_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Offer one request word after a random gap and hold it until taken.
    // Inputs move on the falling edge; acceptance is judged at the rising edge.
    task automatic push_word(input logic cmd, input logic [tabu_pkg::SIZE_W-1:0] size);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_alloc_size <= size;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        board.take_request(cmd, size);
    endtask

    task automatic alloc(input int unsigned size);
        push_word(CMD_ALLOC, tabu_pkg::SIZE_W'(size));
    endtask

    // Wait until every owed result word is back, then let the block go quiet.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.owed() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Only called while idle; the tracker follows the register at once.
    task automatic write_hold(input logic value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        board.set_hold(value);
    endtask

    // Random request mix: small sizes most often so the low tiers fill and spill
    // upward, some mid and tier-sized requests, some full 16-bit sizes
    // (mostly misses), and refill commands at the given percentage.
    task automatic random_words(input int count, input int refill_pct);
        int unsigned sel;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < refill_pct)
                push_word(CMD_REFILL, tabu_pkg::SIZE_W'($urandom));
            else if (sel < 50)
                alloc($urandom_range(0, 200));
            else if (sel < 80)
                alloc($urandom_range(201, 2000));
            else if (sel < 92)
                alloc($urandom_range(2001, 16400));
            else
                alloc($urandom_range(0, 65535));
        end
    endtask

    // Receiver: per word, a random hold-off, then take the word and check it.
    // A squeeze request turns one hold-off into a long one so the block backs
    // up and raises o_in_stall while the sender keeps offering.
    initial begin
        int unsigned hold;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (squeeze_req) begin
                hold        = SQUEEZE_CYCLES;
                squeeze_req = 1'b0;
            end else begin
                hold = no_gaps ? 0 : $urandom_range(0, 15);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            board.match_grant(o_address, o_tier, o_too_large);
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 1'b0;
        i_in_valid    = 1'b0;
        i_cmd         = CMD_ALLOC;
        i_alloc_size  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_hold(1'b0);

        // Directed: zero size, rounding edges, exact tier fill, zero size on a
        // full tier, top tier exact fit, misses at the size extremes, refill.
        alloc(0);
        alloc(1);
        alloc(7);
        alloc(8);
        alloc(9);
        alloc(0);
        alloc(88);        // tier 0 now exactly full
        alloc(0);         // zero bytes still granted at tier 0's end
        alloc(1);         // spills to tier 1
        alloc(16384);     // whole top tier
        alloc(16384);     // nothing left that big
        alloc(65535);     // rounds past 16 bits
        alloc(65529);
        alloc(16377);
        push_word(CMD_REFILL, 16'hFFFF);
        alloc(16377);
        alloc(8192);
        push_word(CMD_REFILL, 16'h0000);
        alloc(256);
        alloc(32768);
        alloc(16'h5555);
        alloc(16'hAAAA);
        settle();

        random_words(120, 5);
        squeeze_req = 1'b1;
        random_words(130, 5);
        // flat-out stretch: no gaps on either side
        no_gaps = 1'b1;
        random_words(60, 5);
        no_gaps = 1'b0;
        settle();

        // Refill commands ignored: the pool only drains until hold is cleared.
        write_hold(1'b1);
        alloc(16384);
        push_word(CMD_REFILL, 16'h1234);
        alloc(16384);
        random_words(100, 10);
        settle();

        // Refills live again; the first one restores the full pool.
        write_hold(1'b0);
        random_words(200, 5);
        settle();

        if (board.errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/tabu_pkg.sv
hw/rtl/tabu_sub_unit.sv
hw/rtl/tabu_space_file.sv
hw/rtl/tiered_arena_bump_allocator_unit.sv
tb/sv/tb_top.sv
